// ===== rtl/mra_pkg.sv =====
// Package for the multi-type reduction ALU: type, operation and register codes,
// payload and inter-stage structs, and small shared helper functions.
// No dependencies.
package mra_pkg;

  localparam logic [2:0] DT_INT8   = 3'd0;
  localparam logic [2:0] DT_UINT8  = 3'd1;
  localparam logic [2:0] DT_INT32  = 3'd2;
  localparam logic [2:0] DT_UINT32 = 3'd3;
  localparam logic [2:0] DT_F32    = 3'd4;
  localparam logic [2:0] DT_F64    = 3'd5;
  localparam logic [2:0] DT_INT64  = 3'd6;
  localparam logic [2:0] DT_UINT64 = 3'd7;

  localparam logic [1:0] OP_SUM  = 2'd0;
  localparam logic [1:0] OP_PROD = 2'd1;
  localparam logic [1:0] OP_MAX  = 2'd2;
  localparam logic [1:0] OP_MIN  = 2'd3;

  localparam logic REG_DATA_TYPE = 1'b0;
  localparam logic REG_REDUCE_OP = 1'b1;

  localparam int CfgWidth = 3;

  // Where the result of an item in flight comes from.
  localparam logic [1:0] SRC_BYP  = 2'd0;
  localparam logic [1:0] SRC_IMUL = 2'd1;
  localparam logic [1:0] SRC_FP   = 2'd2;

  typedef struct packed {
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic        last_in;
  } in_t;

  typedef struct packed {
    logic [63:0] result;
    logic        last_out;
  } out_t;

  typedef struct packed {
    logic [1:0]         src;
    logic [63:0]        res;
    logic               last;
    logic [63:0]        mx;
    logic [63:0]        my;
    logic               sign;
    logic               eff_sub;
    logic               zsign;
    logic [52:0]        sig_l;
    logic [52:0]        sig_s;
    logic signed [13:0] exp_l;
    logic signed [13:0] exp_s;
  } unp_t;

  typedef struct packed {
    logic [1:0]         src;
    logic [63:0]        res;
    logic               last;
    logic               sign;
    logic               zsign;
    logic [127:0]       mag;
    logic signed [13:0] expo;
  } sum_t;

  typedef struct packed {
    logic [1:0]         src;
    logic [63:0]        res;
    logic               last;
    logic               sign;
    logic [63:0]        n64;
    logic               st;
    logic signed [13:0] e64;
  } nrm_t;

  function automatic logic [63:0] type_mask(logic [2:0] dt);
    logic [63:0] m;
    unique case (dt)
      DT_INT8, DT_UINT8:            m = 64'h0000_0000_0000_00FF;
      DT_INT32, DT_UINT32, DT_F32:  m = 64'h0000_0000_FFFF_FFFF;
      default:                      m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  // Signed zero or signed infinity in the selected float format.
  function automatic logic [63:0] fp_const(logic is64, logic sign, logic inf);
    logic [63:0] v;
    if (is64) begin
      v = {sign, inf ? 11'h7FF : 11'h000, 52'b0};
    end else begin
      v = {32'b0, sign, inf ? 8'hFF : 8'h00, 23'b0};
    end
    return v;
  endfunction

endpackage

// ===== rtl/mra_unpack.sv =====
// First pipeline stage of the reduction ALU: operand masking, integer sum and
// compare, float unpacking, special-case results and operand ordering.
// Depends on mra_pkg.
module mra_unpack (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  mra_pkg::in_t   in_i,
  input  logic [2:0]     data_type_i,
  input  logic [1:0]     reduce_op_i,
  output logic           valid_o,
  output mra_pkg::unp_t  unp_o
);

  logic               is_fp, is64f, sgn_int;
  logic [63:0]        mask, flip, am, bm, ka, kb, int_sum, cmp_res, qbit;
  logic               sa, sb, nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic               mag_gt, mag_lt, gt, lt, a_big, pick_a;
  logic [62:0]        maga, magb, inf_pat;
  logic [10:0]        ea, eb;
  logic [52:0]        siga, sigb;
  logic signed [13:0] xa, xb, bias;
  mra_pkg::unp_t      unp_d;
  logic               valid_q;

  always_comb begin
    is_fp   = (data_type_i == mra_pkg::DT_F32) || (data_type_i == mra_pkg::DT_F64);
    is64f   = (data_type_i == mra_pkg::DT_F64);
    sgn_int = (data_type_i == mra_pkg::DT_INT8) || (data_type_i == mra_pkg::DT_INT32) ||
              (data_type_i == mra_pkg::DT_INT64);
    mask    = mra_pkg::type_mask(data_type_i);
    am      = in_i.operand_a & mask;
    bm      = in_i.operand_b & mask;

    unique case (data_type_i)
      mra_pkg::DT_INT8:  flip = 64'h0000_0000_0000_0080;
      mra_pkg::DT_INT32: flip = 64'h0000_0000_8000_0000;
      mra_pkg::DT_INT64: flip = 64'h8000_0000_0000_0000;
      default:           flip = 64'h0;
    endcase
    if (!sgn_int) begin
      flip = 64'h0;
    end
    ka      = am ^ flip;
    kb      = bm ^ flip;
    int_sum = (am + bm) & mask;

    sa      = is64f ? am[63] : am[31];
    sb      = is64f ? bm[63] : bm[31];
    maga    = is64f ? am[62:0] : {32'b0, am[30:0]};
    magb    = is64f ? bm[62:0] : {32'b0, bm[30:0]};
    inf_pat = is64f ? {11'h7FF, 52'b0} : 63'h0000_0000_7F80_0000;
    nan_a   = maga > inf_pat;
    nan_b   = magb > inf_pat;
    inf_a   = maga == inf_pat;
    inf_b   = magb == inf_pat;
    zero_a  = maga == 63'b0;
    zero_b  = magb == 63'b0;
    mag_gt  = maga > magb;
    mag_lt  = maga < magb;
    a_big   = !mag_lt;
    qbit    = is64f ? 64'h0008_0000_0000_0000 : 64'h0000_0000_0040_0000;

    if (is_fp) begin
      if (nan_a || nan_b || (zero_a && zero_b)) begin
        gt = 1'b0;
        lt = 1'b0;
      end else if (sa != sb) begin
        gt = !sa;
        lt = sa;
      end else begin
        gt = sa ? mag_lt : mag_gt;
        lt = sa ? mag_gt : mag_lt;
      end
    end else begin
      gt = ka > kb;
      lt = ka < kb;
    end
    pick_a  = (reduce_op_i == mra_pkg::OP_MAX) ? gt : lt;
    cmp_res = pick_a ? am : bm;

    ea   = is64f ? am[62:52] : {3'b0, am[30:23]};
    eb   = is64f ? bm[62:52] : {3'b0, bm[30:23]};
    siga = is64f ? {ea != 11'd0, am[51:0]} : {ea != 11'd0, am[22:0], 29'b0};
    sigb = is64f ? {eb != 11'd0, bm[51:0]} : {eb != 11'd0, bm[22:0], 29'b0};
    bias = is64f ? 14'sd1075 : 14'sd179;
    xa   = $signed({3'b000, (ea == 11'd0) ? 11'd1 : ea}) - bias;
    xb   = $signed({3'b000, (eb == 11'd0) ? 11'd1 : eb}) - bias;

    unp_d.last    = in_i.last_in;
    unp_d.mx      = am;
    unp_d.my      = bm;
    unp_d.sig_l   = a_big ? siga : sigb;
    unp_d.sig_s   = a_big ? sigb : siga;
    unp_d.exp_l   = a_big ? xa : xb;
    unp_d.exp_s   = a_big ? xb : xa;
    unp_d.eff_sub = sa ^ sb;
    unp_d.zsign   = sa & sb;
    unp_d.sign    = (reduce_op_i == mra_pkg::OP_PROD) ? (sa ^ sb) : (a_big ? sa : sb);
    unp_d.src     = mra_pkg::SRC_BYP;
    unp_d.res     = int_sum;

    if (!is_fp) begin
      unique case (reduce_op_i)
        mra_pkg::OP_SUM:  unp_d.res = int_sum;
        mra_pkg::OP_PROD: unp_d.src = mra_pkg::SRC_IMUL;
        default:          unp_d.res = cmp_res;
      endcase
    end else begin
      unp_d.mx = {11'b0, unp_d.sig_l};
      unp_d.my = {11'b0, unp_d.sig_s};
      if ((reduce_op_i == mra_pkg::OP_MAX) || (reduce_op_i == mra_pkg::OP_MIN)) begin
        unp_d.res = cmp_res;
      end else if (nan_a) begin
        unp_d.res = am | qbit;
      end else if (nan_b) begin
        unp_d.res = bm | qbit;
      end else if (reduce_op_i == mra_pkg::OP_SUM) begin
        if (inf_a && inf_b && (sa != sb)) begin
          unp_d.res = is64f ? 64'h7FF8_0000_0000_0000 : 64'h0000_0000_7FC0_0000;
        end else if (inf_a) begin
          unp_d.res = am;
        end else if (inf_b) begin
          unp_d.res = bm;
        end else if (zero_a && zero_b) begin
          unp_d.res = mra_pkg::fp_const(is64f, sa & sb, 1'b0);
        end else begin
          unp_d.src = mra_pkg::SRC_FP;
        end
      end else begin
        if ((inf_a && zero_b) || (zero_a && inf_b)) begin
          unp_d.res = is64f ? 64'h7FF8_0000_0000_0000 : 64'h0000_0000_7FC0_0000;
        end else if (inf_a || inf_b) begin
          unp_d.res = mra_pkg::fp_const(is64f, sa ^ sb, 1'b1);
        end else if (zero_a || zero_b) begin
          unp_d.res = mra_pkg::fp_const(is64f, sa ^ sb, 1'b0);
        end else begin
          unp_d.src = mra_pkg::SRC_FP;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unp_o <= unp_d;
    end
  end

  assign valid_o = valid_q;

endmodule

// ===== rtl/mra_core.sv =====
// Arithmetic stages of the reduction ALU: four 32x32 partial products and the
// float operand alignment, then the product sum and the significand add.
// Depends on mra_pkg.
module mra_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  mra_pkg::unp_t  unp_i,
  input  logic [2:0]     data_type_i,
  input  logic [1:0]     reduce_op_i,
  output logic           valid_o,
  output mra_pkg::sum_t  sum_o
);

  logic signed [13:0] diff, expo_d;
  logic [5:0]         sh;
  logic [55:0]        s_ext, al_d;
  logic [111:0]       tmp;

  logic               vb_q, vc_q;
  logic [63:0]        pp0_q, pp1_q, pp2_q, pp3_q;
  logic [55:0]        lext_q, al_q;
  logic signed [13:0] expo_q;
  logic [1:0]         src_q;
  logic [63:0]        res_q;
  logic               last_q, sign_q, zsign_q, eff_sub_q;

  logic [127:0]       prod;
  logic [56:0]        addr;
  mra_pkg::sum_t      sum_d;

  always_comb begin
    diff   = unp_i.exp_l - unp_i.exp_s;
    sh     = (diff > 14'sd56) ? 6'd56 : diff[5:0];
    s_ext  = {unp_i.sig_s, 3'b000};
    tmp    = {s_ext, 56'b0} >> sh;
    al_d   = tmp[111:56] | {55'b0, |tmp[55:0]};
    expo_d = (reduce_op_i == mra_pkg::OP_PROD) ? (unp_i.exp_l + unp_i.exp_s)
                                               : (unp_i.exp_l - 14'sd3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      vb_q <= valid_i;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pp0_q     <= unp_i.mx[31:0]  * unp_i.my[31:0];
      pp1_q     <= unp_i.mx[31:0]  * unp_i.my[63:32];
      pp2_q     <= unp_i.mx[63:32] * unp_i.my[31:0];
      pp3_q     <= unp_i.mx[63:32] * unp_i.my[63:32];
      lext_q    <= {unp_i.sig_l, 3'b000};
      al_q      <= al_d;
      expo_q    <= expo_d;
      src_q     <= unp_i.src;
      res_q     <= unp_i.res;
      last_q    <= unp_i.last;
      sign_q    <= unp_i.sign;
      zsign_q   <= unp_i.zsign;
      eff_sub_q <= unp_i.eff_sub;
    end
  end

  always_comb begin
    prod = {64'b0, pp0_q} + {32'b0, pp1_q, 32'b0} + {32'b0, pp2_q, 32'b0} + {pp3_q, 64'b0};
    addr = eff_sub_q ? ({1'b0, lext_q} - {1'b0, al_q}) : ({1'b0, lext_q} + {1'b0, al_q});
    sum_d.src   = src_q;
    sum_d.res   = res_q;
    sum_d.last  = last_q;
    sum_d.sign  = sign_q;
    sum_d.zsign = zsign_q;
    sum_d.expo  = expo_q;
    sum_d.mag   = (reduce_op_i == mra_pkg::OP_PROD) ? prod : {71'b0, addr};
    if (src_q == mra_pkg::SRC_IMUL) begin
      sum_d.src = mra_pkg::SRC_BYP;
      sum_d.res = prod[63:0] & mra_pkg::type_mask(data_type_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sum_o <= sum_d;
    end
  end

  assign valid_o = vc_q;

endmodule

// ===== rtl/mra_norm.sv =====
// Normalization stages of the reduction ALU: leading-zero count of the wide
// significand, then the left shift that brings the leading one to the top.
// Depends on mra_pkg.
module mra_norm (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  mra_pkg::sum_t  sum_i,
  input  logic [2:0]     data_type_i,
  output logic           valid_o,
  output mra_pkg::nrm_t  nrm_o
);

  function automatic logic [6:0] lzc128(logic [127:0] v);
    logic [6:0] n;
    n = 7'd0;
    for (int i = 0; i < 128; i++) begin
      if (v[i]) begin
        n = 7'(127 - i);
      end
    end
    return n;
  endfunction

  logic               vd_q, ve_q;
  mra_pkg::sum_t      sd_q;
  mra_pkg::sum_t      sd_d;
  logic [6:0]         lz_q;
  logic [1:0]         src_d;
  logic [63:0]        res_d;
  logic [127:0]       shifted;
  mra_pkg::nrm_t      nrm_d;

  always_comb begin
    src_d = sum_i.src;
    res_d = sum_i.res;
    if ((sum_i.src == mra_pkg::SRC_FP) && (sum_i.mag == 128'b0)) begin
      src_d = mra_pkg::SRC_BYP;
      res_d = mra_pkg::fp_const(data_type_i == mra_pkg::DT_F64, sum_i.zsign, 1'b0);
    end
    sd_d     = sum_i;
    sd_d.src = src_d;
    sd_d.res = res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else if (en_i) begin
      vd_q <= valid_i;
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sd_q <= sd_d;
      lz_q <= lzc128(sum_i.mag);
    end
  end

  always_comb begin
    shifted     = sd_q.mag << lz_q;
    nrm_d.src   = sd_q.src;
    nrm_d.res   = sd_q.res;
    nrm_d.last  = sd_q.last;
    nrm_d.sign  = sd_q.sign;
    nrm_d.n64   = shifted[127:64];
    nrm_d.st    = |shifted[63:0];
    nrm_d.e64   = sd_q.expo - $signed({7'b0, lz_q}) + 14'sd64;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nrm_o <= nrm_d;
    end
  end

  assign valid_o = ve_q;

endmodule

// ===== rtl/mra_round.sv =====
// Rounding stages of the reduction ALU: right shift to the target precision
// with round and sticky bits, then round-to-nearest-even, packing and the
// output register. Depends on mra_pkg.
module mra_round (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  mra_pkg::nrm_t  nrm_i,
  input  logic [2:0]     data_type_i,
  output logic           valid_o,
  output mra_pkg::out_t  out_o
);

  logic               is64f;
  logic signed [13:0] prec, emin, qn, q, r14;
  logic [6:0]         r;
  logic [127:0]       shifted;

  logic               vf_q, vg_q;
  logic [53:0]        t_q;
  logic               rnd_q, stk_q, sign_q, last_q;
  logic signed [13:0] q_q;
  logic [1:0]         src_q;
  logic [63:0]        res_q;

  logic               inc, carry, normal, ovf;
  logic [53:0]        t2, tn;
  logic signed [13:0] q2, ebias;
  logic [10:0]        efield;
  mra_pkg::out_t      out_d;

  always_comb begin
    is64f   = (data_type_i == mra_pkg::DT_F64);
    prec    = is64f ? 14'sd53 : 14'sd24;
    emin    = is64f ? -14'sd1074 : -14'sd149;
    qn      = nrm_i.e64 + 14'sd64 - prec;
    q       = (qn < emin) ? emin : qn;
    r14     = q - nrm_i.e64;
    r       = (r14 > 14'sd66) ? 7'd66 : r14[6:0];
    shifted = {nrm_i.n64, 64'b0} >> r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
      vg_q <= 1'b0;
    end else if (en_i) begin
      vf_q <= valid_i;
      vg_q <= vf_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q    <= shifted[117:64];
      rnd_q  <= shifted[63];
      stk_q  <= (|shifted[62:0]) | nrm_i.st;
      q_q    <= q;
      sign_q <= nrm_i.sign;
      last_q <= nrm_i.last;
      src_q  <= nrm_i.src;
      res_q  <= nrm_i.res;
    end
  end

  always_comb begin
    inc    = rnd_q & (stk_q | t_q[0]);
    t2     = t_q + {53'b0, inc};
    carry  = is64f ? t2[53] : t2[24];
    tn     = carry ? (t2 >> 1) : t2;
    q2     = q_q + $signed({13'b0, carry});
    normal = is64f ? tn[52] : tn[23];
    ebias  = normal ? (q2 - emin + 14'sd1) : 14'sd0;
    ovf    = is64f ? (ebias >= 14'sd2047) : (ebias >= 14'sd255);
    efield = ebias[10:0];
    out_d.last_out = last_q;
    if (src_q != mra_pkg::SRC_FP) begin
      out_d.result = res_q;
    end else if (ovf) begin
      out_d.result = mra_pkg::fp_const(is64f, sign_q, 1'b1);
    end else if (is64f) begin
      out_d.result = {sign_q, efield, tn[51:0]};
    end else begin
      out_d.result = {32'b0, sign_q, efield[7:0], tn[22:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_o <= out_d;
    end
  end

  assign valid_o = vg_q;

endmodule

// ===== rtl/multi_type_reduction_alu.sv =====
// Top level of the multi-type reduction ALU: configuration registers, pipeline
// enable and the four pipeline sections. Depends on mra_pkg and all mra_ modules.
//
// Usage: each input transaction carries one pair of elements and a last flag
// on in_i, qualified by in_valid_i and accepted when in_stall_o is low. Each
// accepted transaction yields exactly one output transaction on out_o,
// qualified by out_valid_o and taken when out_stall_i is low. The element type
// and the operation (sum, product, maximum, minimum) come from two registers
// written through cfg_we_i, cfg_idx_i and cfg_data_i while no transaction is
// in flight.
// There are seven register stages from acceptance to out_valid_o: unpack,
// partial products and alignment, product sum and add, leading-zero count,
// normalize shift, rounding shift, round and pack. Throughput is one
// transaction per cycle for every type and operation unless the pipeline holds.
// Reset clears the valid bits of all stages and sets both registers to zero
// (int8, sum). When a result waits with out_stall_i high the whole pipeline
// holds and in_stall_o rises in the same cycle; nothing is lost or repeated.
module multi_type_reduction_alu (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mra_pkg::in_t                  in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mra_pkg::out_t                 out_o,
  input  logic                          cfg_we_i,
  input  logic                          cfg_idx_i,
  input  logic [mra_pkg::CfgWidth-1:0]  cfg_data_i
);

  logic [2:0]    data_type_q;
  logic [1:0]    reduce_op_q;
  logic          en;
  logic          v_unp, v_sum, v_nrm;
  mra_pkg::unp_t unp;
  mra_pkg::sum_t sum;
  mra_pkg::nrm_t nrm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_type_q <= mra_pkg::DT_INT8;
      reduce_op_q <= mra_pkg::OP_SUM;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == mra_pkg::REG_DATA_TYPE) begin
        data_type_q <= cfg_data_i[2:0];
      end else begin
        reduce_op_q <= cfg_data_i[1:0];
      end
    end
  end

  assign en         = !(out_valid_o && out_stall_i);
  assign in_stall_o = !en;

  mra_unpack u_unpack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (in_valid_i),
    .in_i        (in_i),
    .data_type_i (data_type_q),
    .reduce_op_i (reduce_op_q),
    .valid_o     (v_unp),
    .unp_o       (unp)
  );

  mra_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (v_unp),
    .unp_i       (unp),
    .data_type_i (data_type_q),
    .reduce_op_i (reduce_op_q),
    .valid_o     (v_sum),
    .sum_o       (sum)
  );

  mra_norm u_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (v_sum),
    .sum_i       (sum),
    .data_type_i (data_type_q),
    .valid_o     (v_nrm),
    .nrm_o       (nrm)
  );

  mra_round u_round (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (v_nrm),
    .nrm_i       (nrm),
    .data_type_i (data_type_q),
    .valid_o     (out_valid_o),
    .out_o       (out_o)
  );

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a waiting output transaction");

  a_upper_zero_8: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (data_type_q == mra_pkg::DT_INT8 || data_type_q == mra_pkg::DT_UINT8))
    |-> (out_o.result[63:8] == 56'b0))
    else $error("8-bit result has nonzero upper bits");

  a_upper_zero_32: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (data_type_q == mra_pkg::DT_INT32 || data_type_q == mra_pkg::DT_UINT32 ||
                     data_type_q == mra_pkg::DT_F32))
    |-> (out_o.result[63:32] == 32'b0))
    else $error("32-bit result has nonzero upper bits");

endmodule
